[rtl/triangle_scanline_span_core_assert.svh]
// assertion macros shared by the span core rtl
`ifndef TRIANGLE_SCANLINE_SPAN_CORE_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TSPAN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tspan assertion failed");
`define TSPAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspan assertion failed");
`else
`define TSPAN_ASSERT(label, prop)
`define TSPAN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/tspan_pkg.sv]
// shared constants, types and helper functions of the span core
package tspan_pkg;

  localparam int SCREEN_SIZE = 256;
  localparam int FRAC_BITS   = 4;
  localparam int COORD_W     = 12;
  localparam int Y_W         = 13;
  localparam int TOP_Y       = (SCREEN_SIZE - 1) * (1 << FRAC_BITS);
  localparam int ROW_W       = 8;
  localparam int ROWF_W      = ROW_W + FRAC_BITS;
  localparam int COL_W       = 9;
  localparam int COLOR_W     = 24;
  localparam int PROD_W      = 26;
  localparam int NUM_W       = 27;
  localparam int MAG_W       = 26;
  localparam int DEN_W       = 16;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STAGES  = MAG_W / DIV_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X, REG_A_Y, REG_B_X, REG_B_Y, REG_C_X, REG_C_Y, REG_TOP_COLOR, REG_BOT_COLOR
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic signed [Y_W-1:0] y;
  } vert_t;

  // sorted geometry, registered from the config
  typedef struct packed {
    vert_t                 a;
    vert_t                 b;
    vert_t                 c;
    logic                  ab_flat;
    logic                  bc_flat;
    logic signed [Y_W-1:0] dx_ab;
    logic signed [Y_W-1:0] dx_ac;
    logic signed [Y_W-1:0] dx_bc;
    logic [COORD_W-1:0]    dy_ab;
    logic [COORD_W-1:0]    dy_ac;
    logic [COORD_W-1:0]    dy_bc;
  } geom_t;

  // edge constant x0*dy - y0*dx per edge
  typedef struct packed {
    logic signed [NUM_W-1:0] k_ab;
    logic signed [NUM_W-1:0] k_ac;
    logic signed [NUM_W-1:0] k_bc;
  } kterm_t;

  typedef struct packed {
    logic [MAG_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t s;
    div_lane_t e;
    logic      covered;
    logic      bottom;
  } div_item_t;

  // two restoring division steps
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t      o;
    logic [DEN_W:0] r;
    o = l;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {o.rem, o.nq[MAG_W-1]};
      o.nq = {o.nq[MAG_W-2:0], 1'b0};
      if (r >= {1'b0, o.den}) begin
        r = r - {1'b0, o.den};
        o.nq[0] = 1'b1;
      end
      o.rem = r[DEN_W-1:0];
    end
    return o;
  endfunction

  function automatic logic row_ge(logic [ROW_W-1:0] row, logic signed [Y_W-1:0] y);
    return (y < 0) || (row >= y[Y_W-2:FRAC_BITS]);
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(logic signed [NUM_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > NUM_W'(SCREEN_SIZE)) begin
      return COL_W'(SCREEN_SIZE);
    end else begin
      return v[COL_W-1:0];
    end
  endfunction

endpackage

[rtl/tspan_ifs.sv]
// row request and span result channel interfaces
interface tspan_row_if import tspan_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row;
  modport source (output valid, output row, input ready);
  modport sink (input valid, input row, output ready);
endinterface

interface tspan_span_if import tspan_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               row_covered;
  logic [COL_W-1:0]   span_start;
  logic [COL_W-1:0]   span_end;
  logic [COLOR_W-1:0] span_color;
  modport source (output valid, output row_covered, output span_start, output span_end,
                  output span_color, input ready);
  modport sink (input valid, input row_covered, input span_start, input span_end,
                input span_color, output ready);
endinterface

[rtl/tspan_setup.sv]
// config registers, vertex sort and per-edge constants
module tspan_setup import tspan_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output geom_t                 geom,
  output kterm_t                kterm,
  output logic [COLOR_W-1:0]    top_color,
  output logic [COLOR_W-1:0]    bot_color
);

  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [COLOR_W-1:0] top_color_r, bot_color_r;
  geom_t  geom_r, geom_nxt;
  kterm_t kterm_r, kterm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r        <= COORD_W'(3019);
      ay_r        <= COORD_W'(2115);
      bx_r        <= COORD_W'(1630);
      by_r        <= COORD_W'(3845);
      cx_r        <= COORD_W'(936);
      cy_r        <= COORD_W'(622);
      top_color_r <= COLOR_W'(255);
      bot_color_r <= COLOR_W'(65280);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_A_X:       ax_r        <= cfg_wdata[COORD_W-1:0];
        REG_A_Y:       ay_r        <= cfg_wdata[COORD_W-1:0];
        REG_B_X:       bx_r        <= cfg_wdata[COORD_W-1:0];
        REG_B_Y:       by_r        <= cfg_wdata[COORD_W-1:0];
        REG_C_X:       cx_r        <= cfg_wdata[COORD_W-1:0];
        REG_C_Y:       cy_r        <= cfg_wdata[COORD_W-1:0];
        REG_TOP_COLOR: top_color_r <= cfg_wdata[COLOR_W-1:0];
        REG_BOT_COLOR: bot_color_r <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // flip y and sort top to bottom
  always_comb begin
    vert_t a, b, c, t;
    t   = '0;
    a.x = ax_r; a.y = Y_W'(TOP_Y) - {1'b0, ay_r};
    b.x = bx_r; b.y = Y_W'(TOP_Y) - {1'b0, by_r};
    c.x = cx_r; c.y = Y_W'(TOP_Y) - {1'b0, cy_r};
    if (a.y > b.y) begin t = a; a = b; b = t; end
    if (b.y > c.y) begin t = b; b = c; c = t; end
    if (a.y > b.y) begin t = a; a = b; b = t; end
    geom_nxt.a       = a;
    geom_nxt.b       = b;
    geom_nxt.c       = c;
    geom_nxt.ab_flat = (a.y == b.y);
    geom_nxt.bc_flat = (b.y == c.y);
    geom_nxt.dx_ab   = {1'b0, b.x} - {1'b0, a.x};
    geom_nxt.dx_ac   = {1'b0, c.x} - {1'b0, a.x};
    geom_nxt.dx_bc   = {1'b0, c.x} - {1'b0, b.x};
    geom_nxt.dy_ab   = COORD_W'(b.y - a.y);
    geom_nxt.dy_ac   = COORD_W'(c.y - a.y);
    geom_nxt.dy_bc   = COORD_W'(c.y - b.y);
  end

  function automatic logic signed [NUM_W-1:0] edge_k(vert_t p, logic [COORD_W-1:0] dy,
                                                     logic signed [Y_W-1:0] dx);
    logic signed [PROD_W-1:0] m0, m1;
    m0 = $signed({1'b0, p.x}) * $signed({1'b0, dy});
    m1 = p.y * dx;
    return NUM_W'(m0) - NUM_W'(m1);
  endfunction

  always_comb begin
    kterm_nxt.k_ab = edge_k(geom_r.a, geom_r.dy_ab, geom_r.dx_ab);
    kterm_nxt.k_ac = edge_k(geom_r.a, geom_r.dy_ac, geom_r.dx_ac);
    kterm_nxt.k_bc = edge_k(geom_r.b, geom_r.dy_bc, geom_r.dx_bc);
  end

  always_ff @(posedge clk) begin
    geom_r  <= geom_nxt;
    kterm_r <= kterm_nxt;
  end

  assign geom      = geom_r;
  assign kterm     = kterm_r;
  assign top_color = top_color_r;
  assign bot_color = bot_color_r;

endmodule

[rtl/tspan_div.sv]
// pipelined two-lane restoring divider, two quotient bits per stage
module tspan_div import tspan_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      v_r   [DIV_STAGES];
  div_item_t stg_r [DIV_STAGES];
  logic      en    [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_item_t src, nxt;
    logic      src_v;
    if (k == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = stg_r[k-1];
      assign src_v = v_r[k-1];
    end
    if (k == DIV_STAGES - 1) begin : g_last
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end

    always_comb begin
      nxt   = src;
      nxt.s = div_step(src.s);
      nxt.e = div_step(src.e);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg_r[k] <= nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_item  = stg_r[DIV_STAGES-1];

endmodule

[rtl/triangle_scanline_span_core.sv]
// triangle scanline span core: top level pipeline
// Returns, for each requested screen row, whether one configured triangle covers it and the
// ordered, clamped span [span_start, span_end) with its color. One row item enters per clock
// and one result leaves per clock while the output is not stalled. The pipe holds
// three front stages (row capture, half select with row*dx multiply, numerator add), thirteen
// divider stages that resolve two quotient bits each, and the output register. A result
// waiting at the output does not stop the pipe until its bubbles are used up. Vertex writes
// pass through the config registers to the sorted geometry register and then to the edge
// constant register.
`include "triangle_scanline_span_core_assert.svh"

module triangle_scanline_span_core import tspan_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tspan_row_if.sink             in_ch,
  tspan_span_if.source          out_ch
);

  geom_t              geom;
  kterm_t             kterm;
  logic [COLOR_W-1:0] top_color, bot_color;

  tspan_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .kterm     (kterm),
    .top_color (top_color),
    .bot_color (bot_color)
  );

  // stall chain: a stage moves when it is empty or the next one moves
  logic en1, en2, en3, en_out;
  logic div_in_ready, div_out_valid;
  div_item_t div_in, div_out;

  logic v1_r, v2_r, v3_r;
  logic [ROW_W-1:0] row1_r;

  // stage 2 payload
  logic                     cov2_r, bot2_r;
  logic signed [PROD_W-1:0] prod_s2_r, prod_e2_r;
  logic [COORD_W-1:0]       dy_s2_r, dy_e2_r;
  logic                     cov2_nxt, bot2_nxt;
  logic signed [PROD_W-1:0] prod_s2_nxt, prod_e2_nxt;

  // stage 3 payload is the divider input
  div_item_t div3_r, div3_nxt;

  assign en_out = !out_ch.valid || out_ch.ready;
  assign en3    = !v3_r || div_in_ready;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // half select and row * dx
  always_comb begin
    logic [ROWF_W-1:0]     rowf;
    logic                  in_bot, in_top;
    logic signed [Y_W-1:0] dx_s;
    rowf   = {row1_r, {FRAC_BITS{1'b0}}};
    // bottom half wins on the row shared with the top half
    in_bot = !geom.bc_flat && row_ge(row1_r, geom.b.y) && ($signed({1'b0, rowf}) <= geom.c.y);
    in_top = !geom.ab_flat && row_ge(row1_r, geom.a.y) && ($signed({1'b0, rowf}) < geom.b.y);
    bot2_nxt    = in_bot;
    cov2_nxt    = in_bot || in_top;
    dx_s        = in_bot ? geom.dx_bc : geom.dx_ab;
    prod_s2_nxt = $signed({1'b0, rowf}) * dx_s;
    prod_e2_nxt = $signed({1'b0, rowf}) * geom.dx_ac;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      row1_r <= in_ch.row;
    end
    if (en2) begin
      cov2_r    <= cov2_nxt;
      bot2_r    <= bot2_nxt;
      prod_s2_r <= prod_s2_nxt;
      prod_e2_r <= prod_e2_nxt;
      dy_s2_r   <= bot2_nxt ? geom.dy_bc : geom.dy_ab;
      dy_e2_r   <= geom.dy_ac;
    end
    if (en3) begin
      div3_r <= div3_nxt;
    end
  end

  // numerator and sign split; divide magnitude by dy scaled to pixels
  always_comb begin
    logic signed [NUM_W-1:0] num_s, num_e;
    num_s = (bot2_r ? kterm.k_bc : kterm.k_ab) + NUM_W'(prod_s2_r);
    num_e = kterm.k_ac + NUM_W'(prod_e2_r);
    div3_nxt.s.neg = num_s[NUM_W-1];
    div3_nxt.s.nq  = MAG_W'(num_s[NUM_W-1] ? -num_s : num_s);
    div3_nxt.s.rem = '0;
    div3_nxt.s.den = {dy_s2_r, {FRAC_BITS{1'b0}}};
    div3_nxt.e.neg = num_e[NUM_W-1];
    div3_nxt.e.nq  = MAG_W'(num_e[NUM_W-1] ? -num_e : num_e);
    div3_nxt.e.rem = '0;
    div3_nxt.e.den = {dy_e2_r, {FRAC_BITS{1'b0}}};
    div3_nxt.covered = cov2_r;
    div3_nxt.bottom  = bot2_r;
  end

  assign div_in = div3_r;

  tspan_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_item   (div_in),
    .out_valid (div_out_valid),
    .out_ready (en_out),
    .out_item  (div_out)
  );

  // sign restore, ordering, clamp
  logic                 out_v_r, cov_r;
  logic [COL_W-1:0]     start_r, end_r;
  logic [COLOR_W-1:0]   color_r;
  logic [COL_W-1:0]     start_nxt, end_nxt;
  logic [COLOR_W-1:0]   color_nxt;

  always_comb begin
    logic signed [NUM_W-1:0] qs, qe, lo, hi;
    qs = div_out.s.neg ? -$signed({1'b0, div_out.s.nq}) : $signed({1'b0, div_out.s.nq});
    qe = div_out.e.neg ? -$signed({1'b0, div_out.e.nq}) : $signed({1'b0, div_out.e.nq});
    lo = (qs > qe) ? qe : qs;
    hi = (qs > qe) ? qs : qe;
    if (div_out.covered) begin
      start_nxt = clamp_col(lo);
      end_nxt   = clamp_col(hi);
      color_nxt = div_out.bottom ? bot_color : top_color;
    end else begin
      start_nxt = '0;
      end_nxt   = '0;
      color_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      cov_r   <= div_out.covered;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      color_r <= color_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.row_covered = cov_r;
  assign out_ch.span_start  = start_r;
  assign out_ch.span_end    = end_r;
  assign out_ch.span_color  = color_r;

  // uncovered rows carry an all-zero span
  `TSPAN_ASSERT(a_uncov_zero, out_ch.valid && !out_ch.row_covered |-> out_ch.span_start == '0 && out_ch.span_end == '0 && out_ch.span_color == '0)
  // span is ordered and inside the screen
  `TSPAN_ASSERT(a_span_order, out_ch.valid |-> out_ch.span_start <= out_ch.span_end && out_ch.span_end <= COL_W'(SCREEN_SIZE))
  // a held result is not replaced while the sink stalls
  `TSPAN_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(start_r) && $stable(end_r))
  // a stalled front stage keeps its row
  `TSPAN_ASSERT_NEXT(a_front_hold, v1_r && !en2, v1_r && $stable(row1_r))

endmodule
